// ===== sv/space_vector_pwm_compare_top_assert.svh =====
// ----------------------------------------------------------------------------
// Space vector PWM compare - assertion macros
// Concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_PWM_COMPARE_TOP_ASSERT_SVH
`define SPACE_VECTOR_PWM_COMPARE_TOP_ASSERT_SVH

// same-cycle implication
`define SVPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SVPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/svpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Space vector PWM compare - package
// Shared widths, fixed-point constants, register map and sector codes.
// ----------------------------------------------------------------------------
package svpc_pkg;

   localparam int VOLT_WIDTH_DEFAULT  = 16;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // 1/sqrt3 in Q16; 2/sqrt3 is twice this value exactly
   localparam int INV_SQRT3_Q16   = 37837;
   localparam int Q16_SHIFT       = 16;
   localparam int INV_SQRT3_WIDTH = 16;
   // one PWM period is 2^28, levels are held doubled (2^29)
   localparam int FRAC_ONE_SHIFT  = 28;
   localparam int LEVEL_SHIFT     = 29;

   localparam int NUM_STAGES = 6;

   // configuration port
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_INDEX_LSB  = 2;
   localparam logic CSR_IDX_PWM_COUNT_MAX = 1'b0;
   localparam int PWM_COUNT_MAX_RESET = 65535;

   typedef enum logic [2:0] {
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5,
      SECTOR_6 = 3'd6
   } sector_type;

endpackage

// ===== sv/svpc_channels.sv =====
// ----------------------------------------------------------------------------
// Space vector PWM compare - channel interfaces
// Valid/ready channels for reference vectors and compare words.
// ----------------------------------------------------------------------------
interface svpc_req_if import svpc_pkg::*; #(
   parameter int VOLT_WIDTH = VOLT_WIDTH_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VOLT_WIDTH-1:0] alpha_voltage;
   logic signed [VOLT_WIDTH-1:0] beta_voltage;

   modport source (output valid, alpha_voltage, beta_voltage, input ready);
   modport sink   (input valid, alpha_voltage, beta_voltage, output ready);
endinterface

interface svpc_rsp_if import svpc_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) ();
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] u_compare;
   logic [COUNT_WIDTH-1:0] v_compare;
   logic [COUNT_WIDTH-1:0] w_compare;
   logic                   invert_outputs;

   modport source (output valid, u_compare, v_compare, w_compare, invert_outputs,
                   input ready);
   modport sink   (input valid, u_compare, v_compare, w_compare, invert_outputs,
                   output ready);
endinterface

// ===== sv/space_vector_pwm_compare_top.sv =====
// Throughput: one word per cycle; the six-stage pipeline only stalls when the
// result consumer holds rsp_chan.ready low and every stage is occupied.
// Reset: synchronous, active high; empties the pipeline and sets
// pwm_count_max to its top value.
// ----------------------------------------------------------------------------
// Space vector PWM compare - top level
// Sector search, dwell times and centre-aligned compare values per vector.
// ----------------------------------------------------------------------------
module space_vector_pwm_compare_top import svpc_pkg::*; #(
   parameter int VOLT_WIDTH  = VOLT_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   svpc_req_if.sink                  req_chan,
   svpc_rsp_if.source                rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

`include "space_vector_pwm_compare_top_assert.svh"

   localparam int PROD_WIDTH  = VOLT_WIDTH + INV_SQRT3_WIDTH;
   localparam int SUM_WIDTH   = VOLT_WIDTH + 17;
   localparam int LEVEL_WIDTH = ((SUM_WIDTH > LEVEL_SHIFT) ? SUM_WIDTH : LEVEL_SHIFT) + 2;
   localparam int SCALE_WIDTH = COUNT_WIDTH + LEVEL_SHIFT;

   // ---------------------------------------------------------------- csr
   logic [COUNT_WIDTH-1:0] count_max_ff, count_max_in;
   logic                   csr_write;
   logic                   csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_INDEX_LSB] == CSR_IDX_PWM_COUNT_MAX);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      count_max_in = count_max_ff;
      if (csr_write && csr_hit) begin
         count_max_in = csr_pwdata[COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = CSR_DATA_WIDTH'(count_max_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_max_ff <= COUNT_WIDTH'(PWM_COUNT_MAX_RESET);
      end else begin
         count_max_ff <= count_max_in;
      end
   end

   // ---------------------------------------------------------- flow control
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] stage_en;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = req_chan.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = stage_en[0];

   // ------------------------------------------------- stage 1: magnitudes
   logic [VOLT_WIDTH-1:0] aa1_ff, aa1_in;
   logic [VOLT_WIDTH-1:0] ba1_ff, ba1_in;
   logic                  alpha_neg1_ff, alpha_neg1_in;
   logic                  beta_neg1_ff, beta_neg1_in;

   always_comb begin
      alpha_neg1_in = req_chan.alpha_voltage[VOLT_WIDTH-1];
      beta_neg1_in  = req_chan.beta_voltage[VOLT_WIDTH-1];
      // most negative input wraps to 2^(w-1), still correct as unsigned
      aa1_in = alpha_neg1_in ? (~req_chan.alpha_voltage + 1'b1) : req_chan.alpha_voltage;
      ba1_in = beta_neg1_in ? (~req_chan.beta_voltage + 1'b1) : req_chan.beta_voltage;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         aa1_ff        <= aa1_in;
         ba1_ff        <= ba1_in;
         alpha_neg1_ff <= alpha_neg1_in;
         beta_neg1_ff  <= beta_neg1_in;
      end
   end

   // ---------------------------------------------- stage 2: |beta|/sqrt3
   logic [PROD_WIDTH-1:0] m2_ff, m2_in;
   logic [VOLT_WIDTH-1:0] aa2_ff;
   logic                  alpha_neg2_ff, beta_neg2_ff;

   assign m2_in = PROD_WIDTH'(ba1_ff) * PROD_WIDTH'(INV_SQRT3_Q16);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         m2_ff         <= m2_in;
         aa2_ff        <= aa1_ff;
         alpha_neg2_ff <= alpha_neg1_ff;
         beta_neg2_ff  <= beta_neg1_ff;
      end
   end

   // ------------------------------------------------- stage 3: a, b and c
   logic signed [SUM_WIDTH-1:0] a3_ff, a3_in;
   logic signed [SUM_WIDTH-1:0] b3_ff, b3_in;
   logic signed [SUM_WIDTH-1:0] c3_ff, c3_in;
   logic signed [SUM_WIDTH-1:0] aa_q16;
   logic signed [SUM_WIDTH-1:0] m_ext;
   logic                        alpha_neg3_ff, beta_neg3_ff;

   always_comb begin
      aa_q16 = {{(SUM_WIDTH - VOLT_WIDTH){1'b0}}, aa2_ff} << Q16_SHIFT;
      m_ext  = {{(SUM_WIDTH - PROD_WIDTH){1'b0}}, m2_ff};
      a3_in  = aa_q16 + m_ext;
      b3_in  = aa_q16 - m_ext;
      c3_in  = m_ext << 1;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         a3_ff         <= a3_in;
         b3_ff         <= b3_in;
         c3_ff         <= c3_in;
         alpha_neg3_ff <= alpha_neg2_ff;
         beta_neg3_ff  <= beta_neg2_ff;
      end
   end

   // ------------------------------------------ stage 4: sector, Ur and Ul
   logic signed [SUM_WIDTH-1:0] ur4_ff, ur4_in;
   logic signed [SUM_WIDTH-1:0] ul4_ff, ul4_in;
   sector_type                  sector4_ff, sector4_in;
   logic                        b_neg;
   logic                        odd_quad;

   always_comb begin
      b_neg    = b3_ff[SUM_WIDTH-1];
      // quadrants 1 and 3 share the same Ur/Ul pattern
      odd_quad = (alpha_neg3_ff == beta_neg3_ff);
      if (b_neg) begin
         ur4_in = odd_quad ? a3_ff : -b3_ff;
         ul4_in = odd_quad ? -b3_ff : a3_ff;
      end else begin
         ur4_in = odd_quad ? b3_ff : c3_ff;
         ul4_in = odd_quad ? c3_ff : b3_ff;
      end
      if (!beta_neg3_ff) begin
         if (b_neg) begin
            sector4_in = SECTOR_2;
         end else begin
            sector4_in = alpha_neg3_ff ? SECTOR_3 : SECTOR_1;
         end
      end else begin
         if (b_neg) begin
            sector4_in = SECTOR_5;
         end else begin
            sector4_in = alpha_neg3_ff ? SECTOR_4 : SECTOR_6;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         ur4_ff     <= ur4_in;
         ul4_ff     <= ul4_in;
         sector4_ff <= sector4_in;
      end
   end

   // --------------------------------- stage 5: switching levels per phase
   logic signed [LEVEL_WIDTH-1:0] level5_ff [3];
   logic signed [LEVEL_WIDTH-1:0] level5_in [3];
   logic                          inv5_ff, inv5_in;
   logic signed [LEVEL_WIDTH-1:0] one_lvl;
   logic signed [LEVEL_WIDTH-1:0] ur_ext;
   logic signed [LEVEL_WIDTH-1:0] ul_ext;
   logic signed [LEVEL_WIDTH-1:0] x2;
   logic signed [LEVEL_WIDTH-1:0] y2;
   logic signed [LEVEL_WIDTH-1:0] z2;

   always_comb begin
      one_lvl = LEVEL_WIDTH'(1) << FRAC_ONE_SHIFT;
      ur_ext  = LEVEL_WIDTH'(ur4_ff);
      ul_ext  = LEVEL_WIDTH'(ul4_ff);
      // doubled levels: 2x = T0, 2y = T0 + 2T1, 2z = 2y + 2T2
      x2 = one_lvl - ur_ext - ul_ext;
      y2 = one_lvl + ur_ext - ul_ext;
      z2 = one_lvl + ur_ext + ul_ext;
      case (sector4_ff) inside
         SECTOR_1, SECTOR_4: begin
            level5_in[0] = x2;
            level5_in[1] = y2;
            level5_in[2] = z2;
         end
         SECTOR_2, SECTOR_5: begin
            level5_in[0] = y2;
            level5_in[1] = z2;
            level5_in[2] = x2;
         end
         default: begin
            level5_in[0] = z2;
            level5_in[1] = x2;
            level5_in[2] = y2;
         end
      endcase
      case (sector4_ff) inside
         SECTOR_2, SECTOR_4, SECTOR_6: inv5_in = 1'b1;
         default:                      inv5_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         level5_ff <= level5_in;
         inv5_ff   <= inv5_in;
      end
   end

   // ------------------------------------ stage 6: scale and saturate
   logic [COUNT_WIDTH-1:0] compare6_ff [3];
   logic [COUNT_WIDTH-1:0] compare6_in [3];
   logic                   inv6_ff;
   logic [SCALE_WIDTH-1:0] scaled [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         scaled[i] = SCALE_WIDTH'(level5_ff[i][LEVEL_SHIFT-1:0])
                     * SCALE_WIDTH'(count_max_ff);
         if (level5_ff[i][LEVEL_WIDTH-1] || (level5_ff[i] == '0)) begin
            compare6_in[i] = '0;
         end else if (|level5_ff[i][LEVEL_WIDTH-2:LEVEL_SHIFT]) begin
            compare6_in[i] = count_max_ff;
         end else begin
            compare6_in[i] = scaled[i][SCALE_WIDTH-1:LEVEL_SHIFT];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         compare6_ff <= compare6_in;
         inv6_ff     <= inv5_ff;
      end
   end

   assign rsp_chan.valid          = valid_ff[NUM_STAGES-1];
   assign rsp_chan.u_compare      = compare6_ff[0];
   assign rsp_chan.v_compare      = compare6_ff[1];
   assign rsp_chan.w_compare      = compare6_ff[2];
   assign rsp_chan.invert_outputs = inv6_ff;

   // ---------------------------------------------------------- assertions
   `SVPC_ASSERT_IMPL(a_compare_in_range, clock, reset, rsp_chan.valid,
      (rsp_chan.u_compare <= count_max_ff) && (rsp_chan.v_compare <= count_max_ff)
      && (rsp_chan.w_compare <= count_max_ff), "compare word above top count")
   `SVPC_ASSERT_IMPL(a_backpressure_full, clock, reset, !req_chan.ready, &valid_ff,
      "input stalled with an empty stage")
   `SVPC_ASSERT_NEXT(a_stage_holds, clock, reset, valid_ff[0] && !stage_en[0],
      valid_ff[0], "stalled first stage lost its word")

endmodule
